// ===== hw/rtl/gc_pkg.sv =====
// Shared constants for the greedy graph coloring unit.
// Depends on nothing; every other file imports it.
`default_nettype none

package gc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int FIELD_W      = 7;
    localparam int ACTION_W     = 2;
    localparam int DEG_W        = 12;

    localparam logic [DEG_W-1:0]    DEG_MAX      = '1;
    localparam logic [FIELD_W-1:0]  VCOUNT_RESET = 7'd64;

    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RUN   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/gc_if.sv =====
// Valid/ready channel interfaces of the graph coloring unit: input items,
// result items and configuration writes. Depends on gc_pkg.
`default_nettype none

interface gc_item_if
    import gc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [FIELD_W-1:0]  src_vertex;
    logic [FIELD_W-1:0]  dst_vertex;

    modport source (output valid, action, src_vertex, dst_vertex, input ready);
    modport sink   (input valid, action, src_vertex, dst_vertex, output ready);
endinterface

interface gc_result_if
    import gc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] vertex_id;
    logic [FIELD_W-1:0] color;
    logic               last;

    modport source (output valid, vertex_id, color, last, input ready);
    modport sink   (input valid, vertex_id, color, last, output ready);
endinterface

interface gc_cfg_if
    import gc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/greedy_graph_coloring_unit.sv =====
// Top level of the greedy graph coloring unit with its four state memories.
// Depends on gc_pkg and the channel interfaces in gc_if.
//
// Edges are loaded one beat at a time, each as a read and a write back of
// the adjacency and degree memories; a dropped edge skips the write back.
// A clear needs no sweep, since per-row valid flops empty the graph at once.
// A run with n vertices first ranks them by out-degree through the single
// read port of the degree memory, then makes one pass per color as the
// order memory feeds adjacency row reads at one vertex a cycle, and finally
// reads the color memory for one result beat at a time. The next item is
// taken as soon as the last result beat sits in the output register.
`default_nettype none

module greedy_graph_coloring_unit
    import gc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    gc_item_if.sink     item,
    gc_result_if.source result,
    gc_cfg_if.sink      cfg
);

    typedef enum logic [7:0] {
        S_IDLE       = 8'b0000_0001,
        S_ADD        = 8'b0000_0010,
        S_RANK_LD    = 8'b0000_0100,
        S_RANK_CAP   = 8'b0000_1000,
        S_RANK_SWEEP = 8'b0001_0000,
        S_COLOR      = 8'b0010_0000,
        S_EMIT_RD    = 8'b0100_0000,
        S_EMIT_WAIT  = 8'b1000_0000
    } state_t;

    logic [MAX_VERTICES-1:0] adj_mem   [MAX_VERTICES];
    logic [DEG_W-1:0]        deg_mem   [MAX_VERTICES];
    logic [FIELD_W-1:0]      color_mem [MAX_VERTICES];
    logic [IDX_W-1:0]        order_mem [MAX_VERTICES];

    logic [MAX_VERTICES-1:0] adj_rdata_reg;
    logic [DEG_W-1:0]        deg_rdata_reg;
    logic [FIELD_W-1:0]      color_rdata_reg;
    logic [IDX_W-1:0]        order_rdata_reg;

    state_t                  state_reg, state_next;
    logic [FIELD_W-1:0]      vertex_count_reg, vertex_count_next;
    logic [MAX_VERTICES-1:0] row_valid_reg, row_valid_next;
    logic [MAX_VERTICES-1:0] colored_reg, colored_next;
    logic [MAX_VERTICES-1:0] pass_mask_reg, pass_mask_next;
    logic                    s1_vld_reg, s1_vld_next;
    logic                    s2_vld_reg, s2_vld_next;
    logic                    out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]        edge_src_reg, edge_src_next;
    logic [IDX_W-1:0]        edge_dst_reg, edge_dst_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        i_reg, i_next;
    logic [CNT_W-1:0]        j_reg, j_next;
    logic [IDX_W-1:0]        jprev_reg, jprev_next;
    logic [IDX_W-1:0]        rank_reg, rank_next;
    logic [DEG_W-1:0]        deg_i_reg, deg_i_next;
    logic [CNT_W-1:0]        k_reg, k_next;
    logic [CNT_W-1:0]        remaining_reg, remaining_next;
    logic [FIELD_W-1:0]      color_reg, color_next;
    logic [IDX_W-1:0]        s2_v_reg, s2_v_next;
    logic [FIELD_W-1:0]      out_vid_reg, out_vid_next;
    logic [FIELD_W-1:0]      out_color_reg, out_color_next;
    logic                    out_last_reg, out_last_next;

    logic                    adj_rd_en, adj_wr_en;
    logic [IDX_W-1:0]        adj_rd_addr, adj_wr_addr;
    logic [MAX_VERTICES-1:0] adj_wr_data;
    logic                    deg_rd_en, deg_wr_en;
    logic [IDX_W-1:0]        deg_rd_addr;
    logic [DEG_W-1:0]        deg_wr_data;
    logic                    order_rd_en, order_wr_en;
    logic [IDX_W-1:0]        order_rd_addr, order_wr_addr, order_wr_data;
    logic                    color_rd_en, color_wr_en;
    logic [IDX_W-1:0]        color_rd_addr, color_wr_addr;

    logic                    accept;
    logic [CNT_W-1:0]        live_n;
    logic [IDX_W-1:0]        src_idx, dst_idx;
    logic                    edge_ok;
    logic [IDX_W-1:0]        deg_sel_idx, adj_sel_idx;
    logic [DEG_W-1:0]        deg_eff;
    logic [MAX_VERTICES-1:0] adj_eff;
    logic [MAX_VERTICES-1:0] dst_bit;
    logic                    hit;
    logic [IDX_W-1:0]        rank_sum;
    logic                    issue, take;
    logic [CNT_W-1:0]        remaining_after;

    assign accept = item.valid && item.ready;
    assign live_n = (vertex_count_reg > FIELD_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                               : CNT_W'(vertex_count_reg);
    assign src_idx = IDX_W'(item.src_vertex - FIELD_W'(1));
    assign dst_idx = IDX_W'(item.dst_vertex - FIELD_W'(1));
    assign edge_ok = (item.src_vertex != '0) && (item.dst_vertex != '0)
                  && (item.src_vertex <= FIELD_W'(live_n))
                  && (item.dst_vertex <= FIELD_W'(live_n));

    assign deg_eff = row_valid_reg[deg_sel_idx] ? deg_rdata_reg : '0;
    assign adj_eff = row_valid_reg[adj_sel_idx] ? adj_rdata_reg : '0;

    assign hit = (deg_eff > deg_i_reg)
              || ((deg_eff == deg_i_reg) && (CNT_W'(jprev_reg) < i_reg));
    assign rank_sum = rank_reg + IDX_W'(hit);

    assign issue = (k_reg < n_reg);
    assign take  = s2_vld_reg && !colored_reg[s2_v_reg]
                && ((adj_eff & pass_mask_reg) == '0);
    assign remaining_after = take ? (remaining_reg - CNT_W'(1)) : remaining_reg;

    always_comb
    begin
        dst_bit = '0;
        dst_bit[edge_dst_reg] = 1'b1;
    end

    assign item.ready       = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign result.valid     = out_valid_reg;
    assign result.vertex_id = out_vid_reg;
    assign result.color     = out_color_reg;
    assign result.last      = out_last_reg;

    always_comb
    begin
        state_next        = state_reg;
        vertex_count_next = cfg.valid ? cfg.vertex_count : vertex_count_reg;
        row_valid_next    = row_valid_reg;
        colored_next      = colored_reg;
        pass_mask_next    = pass_mask_reg;
        s1_vld_next       = 1'b0;
        s2_vld_next       = 1'b0;
        out_valid_next    = out_valid_reg && !result.ready;
        edge_src_next     = edge_src_reg;
        edge_dst_next     = edge_dst_reg;
        n_next            = n_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        jprev_next        = jprev_reg;
        rank_next         = rank_reg;
        deg_i_next        = deg_i_reg;
        k_next            = k_reg;
        remaining_next    = remaining_reg;
        color_next        = color_reg;
        s2_v_next         = s2_v_reg;
        out_vid_next      = out_vid_reg;
        out_color_next    = out_color_reg;
        out_last_next     = out_last_reg;

        adj_rd_en     = 1'b0;
        adj_rd_addr   = src_idx;
        adj_wr_en     = 1'b0;
        adj_wr_addr   = edge_src_reg;
        adj_wr_data   = adj_eff | dst_bit;
        deg_rd_en     = 1'b0;
        deg_rd_addr   = src_idx;
        deg_wr_en     = 1'b0;
        deg_wr_data   = (deg_eff == DEG_MAX) ? deg_eff : (deg_eff + DEG_W'(1));
        order_rd_en   = 1'b0;
        order_rd_addr = k_reg[IDX_W-1:0];
        order_wr_en   = 1'b0;
        order_wr_addr = rank_sum;
        order_wr_data = i_reg[IDX_W-1:0];
        color_rd_en   = 1'b0;
        color_rd_addr = k_reg[IDX_W-1:0];
        color_wr_en   = 1'b0;
        color_wr_addr = s2_v_reg;
        deg_sel_idx   = edge_src_reg;
        adj_sel_idx   = edge_src_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.action)
                        ACT_ADD:
                        begin
                            if (edge_ok)
                            begin
                                adj_rd_en     = 1'b1;
                                deg_rd_en     = 1'b1;
                                edge_src_next = src_idx;
                                edge_dst_next = dst_idx;
                                state_next    = S_ADD;
                            end
                        end
                        ACT_RUN:
                        begin
                            colored_next = '0;
                            n_next       = live_n;
                            i_next       = '0;
                            state_next   = (live_n == '0) ? S_IDLE : S_RANK_LD;
                        end
                        ACT_CLEAR:
                        begin
                            row_valid_next = '0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                adj_wr_en                    = 1'b1;
                deg_wr_en                    = 1'b1;
                row_valid_next[edge_src_reg] = 1'b1;
                state_next                   = S_IDLE;
            end
            S_RANK_LD:
            begin
                deg_rd_en   = 1'b1;
                deg_rd_addr = i_reg[IDX_W-1:0];
                state_next  = S_RANK_CAP;
            end
            S_RANK_CAP:
            begin
                deg_sel_idx = i_reg[IDX_W-1:0];
                deg_i_next  = deg_eff;
                deg_rd_en   = 1'b1;
                deg_rd_addr = '0;
                jprev_next  = '0;
                j_next      = CNT_W'(1);
                rank_next   = '0;
                state_next  = S_RANK_SWEEP;
            end
            S_RANK_SWEEP:
            begin
                deg_sel_idx = jprev_reg;
                if (j_reg < n_reg)
                begin
                    deg_rd_en   = 1'b1;
                    deg_rd_addr = j_reg[IDX_W-1:0];
                    jprev_next  = j_reg[IDX_W-1:0];
                    j_next      = j_reg + CNT_W'(1);
                    rank_next   = rank_sum;
                end
                else
                begin
                    order_wr_en = 1'b1;
                    if ((i_reg + CNT_W'(1)) == n_reg)
                    begin
                        color_next     = FIELD_W'(1);
                        remaining_next = n_reg;
                        pass_mask_next = '0;
                        k_next         = '0;
                        state_next     = S_COLOR;
                    end
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = S_RANK_LD;
                    end
                end
            end
            S_COLOR:
            begin
                adj_sel_idx = s2_v_reg;
                if (issue)
                begin
                    order_rd_en = 1'b1;
                    k_next      = k_reg + CNT_W'(1);
                end
                s1_vld_next = issue;
                if (s1_vld_reg)
                begin
                    adj_rd_en   = 1'b1;
                    adj_rd_addr = order_rdata_reg;
                    s2_v_next   = order_rdata_reg;
                end
                s2_vld_next = s1_vld_reg;
                if (take)
                begin
                    color_wr_en              = 1'b1;
                    colored_next[s2_v_reg]   = 1'b1;
                    pass_mask_next[s2_v_reg] = 1'b1;
                end
                remaining_next = remaining_after;
                if ((k_reg == n_reg) && !s1_vld_reg && s2_vld_reg)
                begin
                    s1_vld_next    = 1'b0;
                    s2_vld_next    = 1'b0;
                    pass_mask_next = '0;
                    k_next         = '0;
                    if (remaining_after == '0)
                    begin
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        color_next = color_reg + FIELD_W'(1);
                    end
                end
            end
            S_EMIT_RD:
            begin
                color_rd_en = 1'b1;
                state_next  = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_vid_next   = FIELD_W'(k_reg + CNT_W'(1));
                    out_color_next = colored_reg[k_reg[IDX_W-1:0]] ? color_rdata_reg : '0;
                    out_last_next  = ((k_reg + CNT_W'(1)) == n_reg);
                    if ((k_reg + CNT_W'(1)) == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            vertex_count_reg <= VCOUNT_RESET;
            row_valid_reg    <= '0;
            colored_reg      <= '0;
            pass_mask_reg    <= '0;
            s1_vld_reg       <= 1'b0;
            s2_vld_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            vertex_count_reg <= vertex_count_next;
            row_valid_reg    <= row_valid_next;
            colored_reg      <= colored_next;
            pass_mask_reg    <= pass_mask_next;
            s1_vld_reg       <= s1_vld_next;
            s2_vld_reg       <= s2_vld_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        edge_src_reg  <= edge_src_next;
        edge_dst_reg  <= edge_dst_next;
        n_reg         <= n_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        jprev_reg     <= jprev_next;
        rank_reg      <= rank_next;
        deg_i_reg     <= deg_i_next;
        k_reg         <= k_next;
        remaining_reg <= remaining_next;
        color_reg     <= color_next;
        s2_v_reg      <= s2_v_next;
        out_vid_reg   <= out_vid_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (adj_wr_en)
        begin
            adj_mem[adj_wr_addr] <= adj_wr_data;
        end
        if (adj_rd_en)
        begin
            adj_rdata_reg <= adj_mem[adj_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (deg_wr_en)
        begin
            deg_mem[edge_src_reg] <= deg_wr_data;
        end
        if (deg_rd_en)
        begin
            deg_rdata_reg <= deg_mem[deg_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (order_wr_en)
        begin
            order_mem[order_wr_addr] <= order_wr_data;
        end
        if (order_rd_en)
        begin
            order_rdata_reg <= order_mem[order_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (color_wr_en)
        begin
            color_mem[color_wr_addr] <= color_reg;
        end
        if (color_rd_en)
        begin
            color_rdata_reg <= color_mem[color_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gc_checker.sv =====
// Port-level checks on the result channel of the graph coloring unit, and
// the bind that attaches them. Depends on gc_pkg and the top level.
`default_nettype none

module gc_checker
    import gc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_ready,
    input wire logic               result_valid,
    input wire logic               result_ready,
    input wire logic               result_last,
    input wire logic [FIELD_W-1:0] result_vertex_id,
    input wire logic [FIELD_W-1:0] result_color
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_vertex_id)
            && $stable(result_color) && $stable(result_last))
        else $error("A stalled result beat changed or was dropped.");

    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_last |-> !item_ready)
        else $error("An item could be taken while a run was still emitting.");

    a_color_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_vertex_id != '0) && (result_color != '0)
            && (result_color <= FIELD_W'(MAX_VERTICES)))
        else $error("A result beat carried an uncolored or out-of-range vertex.");

    a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result_last |=> !result_valid
            || (result_vertex_id == ($past(result_vertex_id) + FIELD_W'(1))))
        else $error("Result vertex ids did not advance by one.");

endmodule

bind greedy_graph_coloring_unit gc_checker u_gc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_ready       (item.ready),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_last      (result.last),
    .result_vertex_id (result.vertex_id),
    .result_color     (result.color)
);

`default_nettype wire
